/* rtl/psw_pkg.sv */
// Shared types and constants for the pausable stopwatch with slot timers.
// No dependencies; every other file of the block imports this package.
package psw_pkg;

    // Size of the slot pool; slot 0 is reserved and never granted.
    localparam int SLOTS  = 8;
    localparam int SLOT_W = $clog2(SLOTS);
    // Holds up to SLOTS-1 slots in use.
    localparam int CNT_W  = $clog2(SLOTS);

    typedef logic [3:0]  action_t;
    typedef logic [2:0]  slot_t;
    typedef logic [31:0] time_t;

    localparam action_t ACT_TICK     = 4'd0;
    localparam action_t ACT_START    = 4'd1;
    localparam action_t ACT_PAUSE    = 4'd2;
    localparam action_t ACT_RESET    = 4'd3;
    localparam action_t ACT_REGISTER = 4'd4;
    localparam action_t ACT_RELEASE  = 4'd5;
    localparam action_t ACT_ARM      = 4'd6;
    localparam action_t ACT_CLEAR    = 4'd7;
    localparam action_t ACT_QUERY    = 4'd8;

    // Command from the stopwatch stage to the slot pool.
    typedef struct packed {
        logic    go;
        action_t action;
        slot_t   slot;
        time_t   duration_ms;
        time_t   elapsed_ms;
    } pool_cmd_t;

    // Status of the addressed slot after the command.
    typedef struct packed {
        logic  slot_valid;
        logic  slot_armed;
        logic  slot_expired;
        slot_t granted_slot;
    } pool_stat_t;

endpackage

/* rtl/psw_if.sv */
// Valid/ready channel interfaces for commands and results.
// Depends on psw_pkg for the payload types.
interface psw_cmd_if;
    logic                valid;
    logic                ready;
    psw_pkg::action_t    action;
    psw_pkg::slot_t      slot;
    psw_pkg::time_t      duration_ms;

    modport source (output valid, action, slot, duration_ms, input ready);
    modport sink   (input valid, action, slot, duration_ms, output ready);
endinterface

interface psw_res_if;
    logic                valid;
    logic                ready;
    psw_pkg::time_t      elapsed_ms;
    logic                slot_valid;
    logic                slot_armed;
    logic                slot_expired;
    psw_pkg::slot_t      granted_slot;

    modport source (output valid, elapsed_ms, slot_valid, slot_armed, slot_expired,
                    granted_slot, input ready);
    modport sink   (input valid, elapsed_ms, slot_valid, slot_armed, slot_expired,
                    granted_slot, output ready);
endinterface

/* rtl/psw_pool.sv */
// Slot pool: allocation marks, use count, per-slot duration and origin.
// Depends on psw_pkg; driven by the top level's processing stage.
module psw_pool (
    input  logic                clk,
    input  logic                rst_n,
    input  psw_pkg::pool_cmd_t  cmd,
    output psw_pkg::pool_stat_t stat
);
    import psw_pkg::*;

    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  used_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    time_t             dur_mem [SLOTS];
    time_t             org_mem [SLOTS];

    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    time_t             wr_dur;
    time_t             wr_org;

    logic [SLOT_W-1:0] s_idx;
    logic              s_ok;
    logic              found;
    logic [SLOT_W-1:0] free_idx;
    logic              grant;
    logic              valid_post;
    time_t             dur_post;
    time_t             org_post;
    time_t             since_arm;

    assign s_idx = SLOT_W'(cmd.slot);
    assign s_ok  = (cmd.slot != '0) && (32'(cmd.slot) < 32'(SLOTS)) && used_reg[s_idx];

    // Find the lowest free slot above the reserved one.
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = 1; i < SLOTS; i++)
        begin
            if (!found && !used_reg[i])
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign grant = cmd.go && (cmd.action == ACT_REGISTER) && found
                   && (cnt_reg < CNT_W'(SLOTS - 1));

    always_comb
    begin
        used_next = used_reg;
        cnt_next  = cnt_reg;
        wr_en     = 1'b0;
        wr_idx    = s_idx;
        wr_dur    = '0;
        wr_org    = '0;
        if (cmd.go)
        begin
            case (cmd.action)
                ACT_RESET:
                begin
                    used_next    = '0;
                    used_next[0] = 1'b1;
                    cnt_next     = '0;
                end
                ACT_REGISTER:
                begin
                    // Fresh slot starts disarmed: zero its entry on grant.
                    if (grant)
                    begin
                        used_next[free_idx] = 1'b1;
                        cnt_next            = cnt_reg + 1'b1;
                        wr_en               = 1'b1;
                        wr_idx              = free_idx;
                    end
                end
                ACT_RELEASE:
                begin
                    if (s_ok)
                    begin
                        used_next[s_idx] = 1'b0;
                        if (cnt_reg != '0)
                            cnt_next = cnt_reg - 1'b1;
                    end
                end
                ACT_ARM:
                begin
                    if (s_ok)
                    begin
                        wr_en  = 1'b1;
                        wr_dur = cmd.duration_ms;
                        wr_org = cmd.elapsed_ms;
                    end
                end
                ACT_CLEAR:
                begin
                    wr_en = s_ok;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            used_reg[0] <= 1'b1;
            cnt_reg     <= '0;
        end
        else
        begin
            used_reg <= used_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dur_mem[wr_idx] <= wr_dur;
            org_mem[wr_idx] <= wr_org;
        end
    end

    // Status after this command: forward the pending write.
    assign valid_post = (cmd.slot != '0) && (32'(cmd.slot) < 32'(SLOTS)) && used_next[s_idx];
    assign dur_post   = (wr_en && wr_idx == s_idx) ? wr_dur : dur_mem[s_idx];
    assign org_post   = (wr_en && wr_idx == s_idx) ? wr_org : org_mem[s_idx];
    assign since_arm  = cmd.elapsed_ms - org_post;

    assign stat.slot_valid   = valid_post;
    assign stat.slot_armed   = valid_post && (dur_post != '0);
    assign stat.slot_expired = valid_post && (since_arm >= dur_post);
    assign stat.granted_slot = grant ? slot_t'(free_idx) : '0;

endmodule

/* rtl/pausable_stopwatch_with_slot_timers.sv */
// Top level of the pausable stopwatch with slot timers.
// Depends on psw_pkg, psw_if and psw_pool.
//
//  channel  | role   | transfer when        | payload
//  ---------+--------+----------------------+-------------------------------------------
//  cmd      | sink   | valid && ready       | action, slot, duration_ms
//  status   | source | valid && ready       | elapsed_ms, slot_valid/armed/expired,
//           |        |                      | granted_slot
//
// One command per cycle is taken at full rate while the status side keeps
// up. A command lands in the input register; once the result register is
// free or being emptied, the stopwatch update and the slot pool update are
// worked out together and the status lands in the result register.
// Reset clears the stopwatch, the allocation marks and both valid flags.
// A stalled status holds the result register and, behind it, the input
// register; the command side goes not-ready only when both are full.
module pausable_stopwatch_with_slot_timers (
    input  logic       clk,
    input  logic       rst_n,
    psw_cmd_if.sink    cmd,
    psw_res_if.source  status
);
    import psw_pkg::*;

    // Input register
    logic       in_v_reg;
    action_t    in_action_reg;
    slot_t      in_slot_reg;
    time_t      in_dur_reg;

    // Stopwatch state
    time_t      now_reg;
    time_t      now_next;
    time_t      origin_reg;
    time_t      origin_next;
    time_t      held_reg;
    time_t      held_next;
    logic       started_reg;
    logic       started_next;
    logic       paused_reg;
    logic       paused_next;

    // Result register
    logic       out_v_reg;
    time_t      out_el_reg;
    pool_stat_t out_stat_reg;

    logic       advance;
    time_t      el_pre;
    time_t      el_post;
    pool_cmd_t  pool_cmd;
    pool_stat_t pool_stat;

    // Move the held command into the result register when that slot is free.
    assign advance   = in_v_reg && (!out_v_reg || status.ready);
    assign cmd.ready = !in_v_reg || advance;

    assign el_pre = paused_reg ? held_reg : (now_reg - origin_reg);

    always_comb
    begin
        now_next     = now_reg;
        origin_next  = origin_reg;
        held_next    = held_reg;
        started_next = started_reg;
        paused_next  = paused_reg;
        case (in_action_reg)
            ACT_TICK:
            begin
                now_next = now_reg + 32'd1;
            end
            ACT_START:
            begin
                // First start latches the origin; a later one resumes from pause.
                if (!started_reg)
                begin
                    origin_next  = now_reg;
                    started_next = 1'b1;
                end
                else if (paused_reg)
                begin
                    origin_next = now_reg - held_reg;
                    paused_next = 1'b0;
                end
            end
            ACT_PAUSE:
            begin
                if (!paused_reg)
                begin
                    held_next   = el_pre;
                    paused_next = 1'b1;
                end
            end
            ACT_RESET:
            begin
                origin_next  = now_reg;
                held_next    = '0;
                started_next = 1'b1;
                paused_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign el_post = paused_next ? held_next : (now_next - origin_next);

    assign pool_cmd.go          = advance;
    assign pool_cmd.action      = in_action_reg;
    assign pool_cmd.slot        = in_slot_reg;
    assign pool_cmd.duration_ms = in_dur_reg;
    assign pool_cmd.elapsed_ms  = el_post;

    psw_pool u_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pool_cmd),
        .stat  (pool_stat)
    );

    // Control and stopwatch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            now_reg     <= '0;
            origin_reg  <= '0;
            held_reg    <= '0;
            started_reg <= 1'b0;
            paused_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
                in_v_reg <= cmd.valid;
            if (advance)
            begin
                out_v_reg   <= 1'b1;
                now_reg     <= now_next;
                origin_reg  <= origin_next;
                held_reg    <= held_next;
                started_reg <= started_next;
                paused_reg  <= paused_next;
            end
            else if (status.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_action_reg <= cmd.action;
            in_slot_reg   <= cmd.slot;
            in_dur_reg    <= cmd.duration_ms;
        end
        if (advance)
        begin
            out_el_reg   <= el_post;
            out_stat_reg <= pool_stat;
        end
    end

    assign status.valid        = out_v_reg;
    assign status.elapsed_ms   = out_el_reg;
    assign status.slot_valid   = out_stat_reg.slot_valid;
    assign status.slot_armed   = out_stat_reg.slot_armed;
    assign status.slot_expired = out_stat_reg.slot_expired;
    assign status.granted_slot = out_stat_reg.granted_slot;

endmodule

/* verif/psw_status_checker.sv */
// Checker for the pausable stopwatch with slot timers: predicts and compares statuses.
// Depends on psw_pkg and the psw_cmd_if / psw_res_if channel interfaces.
`timescale 1ns / 1ps

module psw_status_checker
(
    input  logic        clk,
    input  logic        rst_n,
    psw_cmd_if          cmd,
    psw_res_if          status,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked,
    output int unsigned expired_seen
);
    import psw_pkg::*;

    typedef struct packed {
        time_t elapsed_ms;
        logic  slot_valid;
        logic  slot_armed;
        logic  slot_expired;
        slot_t granted_slot;
    } status_rec_t;

    // Predicted stopwatch and pool state.
    time_t             now_count;
    time_t             origin;
    time_t             held;
    logic              started;
    logic              paused;
    logic              used     [SLOTS];
    time_t             slot_dur [SLOTS];
    time_t             slot_org [SLOTS];
    logic [CNT_W-1:0]  in_use;

    status_rec_t       status_due [$];
    status_rec_t       due;

    function automatic void clear_pool();
        for (int i = 0; i < SLOTS; i++)
        begin
            used[i]     = 1'b0;
            slot_dur[i] = '0;
            slot_org[i] = '0;
        end
        used[0] = 1'b1;
        in_use  = '0;
    endfunction

    function automatic time_t elapsed_now();
        return paused ? held : time_t'(now_count - origin);
    endfunction

    function automatic logic slot_live(slot_t s);
        return (s != '0) && (int'(s) < SLOTS) && used[s];
    endfunction

    // Advance the stopwatch and pool by one command; return the status it causes.
    function automatic status_rec_t predict_status(action_t act, slot_t s, time_t d);
        status_rec_t r;
        logic        found;
        logic        ok;
        r     = '0;
        found = 1'b0;
        case (act)
            ACT_TICK:  now_count = now_count + 32'd1;
            ACT_START:
            begin
                if (!started)
                begin
                    origin  = now_count;
                    started = 1'b1;
                end
                else if (paused)
                begin
                    origin = now_count - held;
                    paused = 1'b0;
                end
            end
            ACT_PAUSE:
            begin
                if (!paused)
                begin
                    held   = elapsed_now();
                    paused = 1'b1;
                end
            end
            ACT_RESET:
            begin
                origin  = now_count;
                held    = '0;
                clear_pool();
                started = 1'b1;
                paused  = 1'b0;
            end
            ACT_REGISTER:
            begin
                if (int'(in_use) < SLOTS - 1)
                begin
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        if (!found && !used[i])
                        begin
                            used[i]        = 1'b1;
                            in_use         = in_use + 1'b1;
                            r.granted_slot = slot_t'(i);
                            found          = 1'b1;
                        end
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (slot_live(s))
                begin
                    if (in_use != '0)
                        in_use = in_use - 1'b1;
                    used[s]     = 1'b0;
                    slot_dur[s] = '0;
                    slot_org[s] = '0;
                end
            end
            ACT_ARM:
            begin
                if (slot_live(s))
                begin
                    slot_dur[s] = d;
                    slot_org[s] = elapsed_now();
                end
            end
            ACT_CLEAR:
            begin
                if (slot_live(s))
                begin
                    slot_dur[s] = '0;
                    slot_org[s] = '0;
                end
            end
            default: ;  // query and unused codes change nothing
        endcase
        ok             = slot_live(s);
        r.elapsed_ms   = elapsed_now();
        r.slot_valid   = ok;
        r.slot_armed   = ok && (slot_dur[s] != '0);
        r.slot_expired = ok && (time_t'(r.elapsed_ms - slot_org[s]) >= slot_dur[s]);
        return r;
    endfunction

    function automatic void check_field(string name, time_t want, time_t got);
        if (want !== got)
        begin
            fail_count = fail_count + 1;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_count    = '0;
            origin       = '0;
            held         = '0;
            started      = 1'b0;
            paused       = 1'b0;
            clear_pool();
            status_due.delete();
            fail_count   = 0;
            checked      = 0;
            expired_seen = 0;
        end
        else
        begin
            // Compare first: a status never belongs to a command taken at the same edge.
            if (status.valid && status.ready)
            begin
                if (status_due.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $error("status transfer with no command outstanding");
                end
                else
                begin
                    due = status_due.pop_front();
                    check_field("elapsed_ms", due.elapsed_ms, status.elapsed_ms);
                    check_field("slot_valid", time_t'(due.slot_valid),
                                time_t'(status.slot_valid));
                    check_field("slot_armed", time_t'(due.slot_armed),
                                time_t'(status.slot_armed));
                    check_field("slot_expired", time_t'(due.slot_expired),
                                time_t'(status.slot_expired));
                    check_field("granted_slot", time_t'(due.granted_slot),
                                time_t'(status.granted_slot));
                    checked = checked + 1;
                    if (due.slot_expired)
                        expired_seen = expired_seen + 1;
                end
            end
            if (cmd.valid && cmd.ready)
                status_due.push_back(predict_status(cmd.action, cmd.slot, cmd.duration_ms));
        end
        pending = status_due.size();
    end

endmodule

/* verif/tb_pausable_stopwatch_with_slot_timers.sv */
// Testbench top for the pausable stopwatch with slot timers: clock, reset, stimulus, verdict.
// Depends on psw_pkg, psw_if, the block under test and psw_status_checker.
`timescale 1ns / 1ps

module tb_pausable_stopwatch_with_slot_timers;

    import psw_pkg::*;

    // Random commands after the directed opening.
    localparam int RANDOM_ITEMS = 600;
    // Watchdog in clock cycles: the slowest run is far below this even with
    // every command waiting out a full sender gap and a long receiver stall.
    localparam int CYCLE_LIMIT  = 200000;
    // Drain allowance once nothing is outstanding: catches any stray status.
    localparam int DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned expired_seen;

    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned directed_sent;
    int unsigned random_sent;

    // Receiver pattern state.
    int unsigned rx_mode;
    int unsigned rx_left;
    int unsigned rx_phase;

    psw_cmd_if cmd_ch ();
    psw_res_if status_ch ();

    pausable_stopwatch_with_slot_timers dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .status (status_ch)
    );

    psw_status_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .status       (status_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .expired_seen (expired_seen)
    );

    // 4 ns clock, starting low so the first falling edge lands at 4 ns.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop if the run hangs, e.g. a lost status or a stuck ready.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d statuses outstanding",
                     cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Status receiver: picks a new stall pattern at random whenever a run ends.
    // Mode 0 takes everything (stretches with no back-pressure), mode 1 is a
    // coin toss, mode 2 drops ready one cycle in four, mode 3 holds off for
    // long runs so that the input register fills and cmd.ready falls.
    initial
    begin
        rx_mode  = 0;
        rx_left  = 0;
        rx_phase = 0;
    end

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 150);
        end
        rx_left  = rx_left - 1;
        rx_phase = rx_phase + 1;
        case (rx_mode)
            0:       status_ch.ready <= 1'b1;
            1:       status_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       status_ch.ready <= ((rx_phase % 4) != 3);
            default: status_ch.ready <= ((rx_phase % 9) < 3);
        endcase
    end

    // Offer one command and hold it until the transfer. Called and returned
    // at a falling edge. Commands go out in bursts; between bursts valid is
    // dropped for a random gap, and some bursts follow on with no gap at all.
    task automatic transfer_command(input action_t a, input slot_t s, input time_t d);
        int unsigned gap;
        begin
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
                if (gap != 0)
                begin
                    cmd_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            cmd_ch.valid       <= 1'b1;
            cmd_ch.action      <= a;
            cmd_ch.slot        <= s;
            cmd_ch.duration_ms <= d;
            burst_left = burst_left - 1;
            @(posedge clk);
            while (!(cmd_ch.valid && cmd_ch.ready))
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic directed_command(input action_t a, input slot_t s, input time_t d);
        begin
            transfer_command(a, s, d);
            directed_sent = directed_sent + 1;
        end
    endtask

    // Random command mix, weighted towards ticks, arming and registration so
    // that slots fill, arm, run out and get recycled. Resets stay rare so the
    // pool reaches full; most slot numbers address real slots, a few hit the
    // reserved slot 0. Durations are mostly short enough to expire within a
    // run of ticks, with some zero and some over the full 32-bit range.
    task automatic random_command();
        int unsigned pick;
        action_t     a;
        slot_t       s;
        time_t       d;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 34)
                a = ACT_TICK;
            else if (pick < 42)
                a = ACT_START;
            else if (pick < 48)
                a = ACT_PAUSE;
            else if (pick < 50)
                a = ACT_RESET;
            else if (pick < 60)
                a = ACT_REGISTER;
            else if (pick < 68)
                a = ACT_RELEASE;
            else if (pick < 80)
                a = ACT_ARM;
            else if (pick < 85)
                a = ACT_CLEAR;
            else if (pick < 95)
                a = ACT_QUERY;
            else
                a = action_t'($urandom_range(9, 15));

            if ($urandom_range(0, 9) == 0)
                s = '0;
            else
                s = slot_t'($urandom_range(1, SLOTS - 1));

            pick = $urandom_range(0, 9);
            if (pick == 0)
                d = '0;
            else if (pick < 3)
                d = $urandom;
            else
                d = $urandom_range(1, 40);

            transfer_command(a, s, d);
            random_sent = random_sent + 1;
        end
    endtask

    initial
    begin
        // Every input known from time zero, with reset held low before the stimulus.
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.action      = ACT_QUERY;
        cmd_ch.slot        = '0;
        cmd_ch.duration_ms = '0;
        status_ch.ready    = 1'b0;
        burst_left         = 0;
        directed_sent      = 0;
        random_sent        = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stopwatch corners. Before any start the elapsed time follows the
        // tick counter; a pause before start captures it, and the following
        // start sets the origin but leaves the pause in place.
        directed_command(ACT_QUERY, 3'd0, '0);
        directed_command(ACT_TICK,  3'd0, '0);
        directed_command(ACT_PAUSE, 3'd0, '0);
        directed_command(ACT_TICK,  3'd0, '0);
        directed_command(ACT_START, 3'd0, '0);
        // Second start resumes from the held time, third is a no-op while running.
        directed_command(ACT_START, 3'd0, '0);
        directed_command(ACT_START, 3'd0, '0);
        // Pause twice: the second must not recapture.
        directed_command(ACT_PAUSE, 3'd0, '0);
        directed_command(ACT_PAUSE, 3'd0, '0);
        directed_command(ACT_START, 3'd0, '0);

        // Fill the pool: seven grants, then a refusal once it is full.
        repeat (SLOTS) directed_command(ACT_REGISTER, 3'd0, '0);

        // Zero duration reports expired at once; the widest duration never
        // expires; the reserved slot ignores arming.
        directed_command(ACT_ARM, 3'd1, '0);
        directed_command(ACT_ARM, 3'd2, 32'hFFFF_FFFF);
        directed_command(ACT_ARM, 3'd0, 32'h0000_0005);
        // Release one slot, disarm another, and use the top unused code on
        // the highest slot, which must read back as a plain query.
        directed_command(ACT_RELEASE, 3'd3, '0);
        directed_command(ACT_CLEAR,   3'd2, '0);
        directed_command(action_t'(15), 3'd7, '0);
        // Reset empties the pool and restarts the stopwatch.
        directed_command(ACT_RESET, 3'd7, '0);

        repeat (RANDOM_ITEMS) random_command();
        cmd_ch.valid <= 1'b0;

        // Drain: wait for every predicted status, then allow for anything stray.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d directed and %0d random commands under bursty traffic",
                 directed_sent, random_sent);
        $display("and receiver stalls; %0d statuses compared, %0d with the slot expired.",
                 checked, expired_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
